### rtl/pps_pkg.sv
package pps_pkg;

    // Table size and derived widths.
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // Fixed field widths of the channels.
    localparam int CMD_W       = 2;
    localparam int TIME_W      = 16;
    localparam int SUM_W       = 32;
    localparam int RAN_INDEX_W = 4;

    // Commands carried by an input transfer.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One process entry as it is kept in the table memory.
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result transfer.
    typedef struct packed {
        logic                   ran_valid;
        logic [RAN_INDEX_W-1:0] ran_index;
        logic                   completed;
        logic [TIME_W-1:0]      clock_now;
        logic                   all_done;
        logic [SUM_W-1:0]       total_turnaround;
        logic [SUM_W-1:0]       total_waiting;
        logic                   table_full;
    } rsp_t;

    // Add two totals and stick at the maximum on overflow.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

### rtl/pps_req_if.sv
interface pps_req_if;
    logic                      valid;
    logic                      ready;
    logic [pps_pkg::CMD_W-1:0]  command;
    logic [pps_pkg::TIME_W-1:0] arrival_time;
    logic [pps_pkg::TIME_W-1:0] burst_time;
    logic [pps_pkg::TIME_W-1:0] priority_value;

    modport source (
        output valid, command, arrival_time, burst_time, priority_value,
        input  ready
    );

    modport sink (
        input  valid, command, arrival_time, burst_time, priority_value,
        output ready
    );
endinterface

### rtl/pps_rsp_if.sv
interface pps_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ran_valid;
    logic [pps_pkg::RAN_INDEX_W-1:0] ran_index;
    logic                            completed;
    logic [pps_pkg::TIME_W-1:0]      clock_now;
    logic                            all_done;
    logic [pps_pkg::SUM_W-1:0]       total_turnaround;
    logic [pps_pkg::SUM_W-1:0]       total_waiting;
    logic                            table_full;

    modport source (
        output valid, ran_valid, ran_index, completed, clock_now, all_done,
               total_turnaround, total_waiting, table_full,
        input  ready
    );

    modport sink (
        input  valid, ran_valid, ran_index, completed, clock_now, all_done,
               total_turnaround, total_waiting, table_full,
        output ready
    );
endinterface

### rtl/pps_ram.sv
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler, one clock tick per tick command. Load commands
// append a process entry (arrival, burst, priority) to a table of
// pps_pkg::MAX_PROCS entries held in a single-port-read RAM; clear empties the
// table and the totals; a tick runs the ready entry with the lowest priority
// value (lowest index on ties). Every command returns exactly one result
// transfer. During a tick the table RAM delivers one entry per cycle to the
// priority compare, and a final step writes back the remaining burst and forms
// the result. Load, clear, the unused command and a tick on an empty table
// skip the scan. A finished result waits in an output register, so the next
// command is taken while it waits; the block stalls only when a second result
// is ready before the first was taken.
module preemptive_priority_scheduler (
    input  logic           clk,
    input  logic           rst_n,
    pps_req_if.sink        req,
    pps_rsp_if.source      rsp
);

    localparam int IDX_W  = pps_pkg::IDX_W;
    localparam int CNT_W  = pps_pkg::CNT_W;
    localparam int TIME_W = pps_pkg::TIME_W;
    localparam int SUM_W  = pps_pkg::SUM_W;

    // Control state.
    pps_pkg::state_t                state_reg, state_next;
    logic [IDX_W-1:0]               rd_idx_reg, rd_idx_next;
    logic                           found_reg, found_next;
    logic [CNT_W-1:0]               ready_cnt_reg, ready_cnt_next;
    logic [pps_pkg::MAX_PROCS-1:0]  finished_marks_reg, finished_marks_next;
    logic [CNT_W-1:0]               entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]               finished_count_reg, finished_count_next;
    logic [TIME_W-1:0]              tick_clock_reg, tick_clock_next;
    logic [SUM_W-1:0]               turnaround_reg, turnaround_next;
    logic [SUM_W-1:0]               waiting_reg, waiting_next;
    logic                           out_valid_reg, out_valid_next;

    // Payload registers.
    pps_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [TIME_W-1:0]              arr_reg, arr_next;
    logic [TIME_W-1:0]              bur_reg, bur_next;
    logic [TIME_W-1:0]              pri_reg, pri_next;
    logic [IDX_W-1:0]               best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]              best_arr_reg, best_arr_next;
    logic [TIME_W-1:0]              best_rem_reg, best_rem_next;
    logic [TIME_W-1:0]              best_pri_reg, best_pri_next;
    pps_pkg::rsp_t                  out_reg, out_next;

    // Table memory ports.
    logic                           ram_we;
    logic [IDX_W-1:0]               ram_waddr;
    pps_pkg::entry_t                ram_wdata;
    logic                           ram_re;
    logic [IDX_W-1:0]               ram_raddr;
    pps_pkg::entry_t                ram_rdata;

    // Scan and commit helpers.
    logic                           entry_ready;
    logic                           entry_take;
    logic [CNT_W-1:0]               scan_count;
    logic                           out_free;
    logic [TIME_W-1:0]              rem_dec;
    logic [TIME_W-1:0]              clock_inc;

    pps_ram #(
        .WIDTH (pps_pkg::ENTRY_W),
        .DEPTH (pps_pkg::MAX_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == pps_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Evaluation of the entry that the memory returns during a scan.
    assign entry_ready = !finished_marks_reg[rd_idx_reg] &&
                         (ram_rdata.arrival <= tick_clock_reg);
    assign entry_take  = entry_ready && (!found_reg || (ram_rdata.prio < best_pri_reg));
    assign scan_count  = CNT_W'(rd_idx_reg) + CNT_W'(1);
    assign rem_dec     = best_rem_reg - TIME_W'(1);
    assign clock_inc   = (tick_clock_reg == {TIME_W{1'b1}}) ?
                         tick_clock_reg : tick_clock_reg + TIME_W'(1);

    // Next state, memory control and result formation.
    always_comb
    begin
        state_next          = state_reg;
        rd_idx_next         = rd_idx_reg;
        found_next          = found_reg;
        ready_cnt_next      = ready_cnt_reg;
        finished_marks_next = finished_marks_reg;
        entry_count_next    = entry_count_reg;
        finished_count_next = finished_count_reg;
        tick_clock_next     = tick_clock_reg;
        turnaround_next     = turnaround_reg;
        waiting_next        = waiting_reg;
        out_valid_next      = out_valid_reg;
        cmd_next            = cmd_reg;
        arr_next            = arr_reg;
        bur_next            = bur_reg;
        pri_next            = pri_reg;
        best_idx_next       = best_idx_reg;
        best_arr_next       = best_arr_reg;
        best_rem_next       = best_rem_reg;
        best_pri_next       = best_pri_reg;
        out_next            = out_reg;
        ram_we              = 1'b0;
        ram_waddr           = best_idx_reg;
        ram_wdata           = '0;
        ram_re              = 1'b0;
        ram_raddr           = '0;

        // The waiting result leaves on its transfer.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = pps_pkg::cmd_t'(req.command);
                    arr_next       = req.arrival_time;
                    bur_next       = req.burst_time;
                    pri_next       = req.priority_value;
                    found_next     = 1'b0;
                    ready_cnt_next = '0;
                    rd_idx_next    = '0;
                    if ((pps_pkg::cmd_t'(req.command) == pps_pkg::CMD_TICK) &&
                        (entry_count_reg != '0))
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = pps_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = pps_pkg::ST_FINISH;
                    end
                end
            end

            pps_pkg::ST_SCAN:
            begin
                // Keep the best ready entry seen so far.
                if (entry_ready)
                begin
                    ready_cnt_next = ready_cnt_reg + CNT_W'(1);
                end
                if (entry_take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_arr_next = ram_rdata.arrival;
                    best_rem_next = ram_rdata.remaining;
                    best_pri_next = ram_rdata.prio;
                end
                if (scan_count >= entry_count_reg)
                begin
                    state_next = pps_pkg::ST_FINISH;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg + IDX_W'(1);
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end

            pps_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next = '0;
                    unique case (cmd_reg)
                        pps_pkg::CMD_LOAD:
                        begin
                            if (entry_count_reg >= CNT_W'(pps_pkg::MAX_PROCS))
                            begin
                                out_next.table_full = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = entry_count_reg[IDX_W-1:0];
                                ram_wdata = '{arrival: arr_reg, remaining: bur_reg,
                                              prio: pri_reg};
                                if (bur_reg == '0)
                                begin
                                    finished_marks_next[entry_count_reg[IDX_W-1:0]] = 1'b1;
                                    finished_count_next = finished_count_reg + CNT_W'(1);
                                end
                                entry_count_next = entry_count_reg + CNT_W'(1);
                            end
                        end

                        pps_pkg::CMD_TICK:
                        begin
                            tick_clock_next = clock_inc;
                            if (found_reg)
                            begin
                                out_next.ran_valid = 1'b1;
                                out_next.ran_index = pps_pkg::RAN_INDEX_W'(best_idx_reg);
                                waiting_next = pps_pkg::sat_add(waiting_reg,
                                    SUM_W'(ready_cnt_reg) - SUM_W'(1));
                                ram_we    = 1'b1;
                                ram_waddr = best_idx_reg;
                                ram_wdata = '{arrival: best_arr_reg, remaining: rem_dec,
                                              prio: best_pri_reg};
                                if (rem_dec == '0)
                                begin
                                    out_next.completed = 1'b1;
                                    finished_marks_next[best_idx_reg] = 1'b1;
                                    finished_count_next = finished_count_reg + CNT_W'(1);
                                    turnaround_next = pps_pkg::sat_add(turnaround_reg,
                                        SUM_W'(clock_inc - best_arr_reg));
                                end
                            end
                        end

                        pps_pkg::CMD_CLEAR:
                        begin
                            finished_marks_next = '0;
                            entry_count_next    = '0;
                            finished_count_next = '0;
                            tick_clock_next     = '0;
                            turnaround_next     = '0;
                            waiting_next        = '0;
                        end

                        pps_pkg::CMD_NOP:
                        begin
                        end

                        default:
                        begin
                        end
                    endcase

                    out_next.clock_now        = tick_clock_next;
                    out_next.all_done         = (finished_count_next == entry_count_next);
                    out_next.total_turnaround = turnaround_next;
                    out_next.total_waiting    = waiting_next;
                    out_valid_next            = 1'b1;
                    state_next                = pps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= pps_pkg::ST_IDLE;
            rd_idx_reg         <= '0;
            found_reg          <= 1'b0;
            ready_cnt_reg      <= '0;
            finished_marks_reg <= '0;
            entry_count_reg    <= '0;
            finished_count_reg <= '0;
            tick_clock_reg     <= '0;
            turnaround_reg     <= '0;
            waiting_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            rd_idx_reg         <= rd_idx_next;
            found_reg          <= found_next;
            ready_cnt_reg      <= ready_cnt_next;
            finished_marks_reg <= finished_marks_next;
            entry_count_reg    <= entry_count_next;
            finished_count_reg <= finished_count_next;
            tick_clock_reg     <= tick_clock_next;
            turnaround_reg     <= turnaround_next;
            waiting_reg        <= waiting_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        arr_reg      <= arr_next;
        bur_reg      <= bur_next;
        pri_reg      <= pri_next;
        best_idx_reg <= best_idx_next;
        best_arr_reg <= best_arr_next;
        best_rem_reg <= best_rem_next;
        best_pri_reg <= best_pri_next;
        out_reg      <= out_next;
    end

    // Result channel.
    assign rsp.valid            = out_valid_reg;
    assign rsp.ran_valid        = out_reg.ran_valid;
    assign rsp.ran_index        = out_reg.ran_index;
    assign rsp.completed        = out_reg.completed;
    assign rsp.clock_now        = out_reg.clock_now;
    assign rsp.all_done         = out_reg.all_done;
    assign rsp.total_turnaround = out_reg.total_turnaround;
    assign rsp.total_waiting    = out_reg.total_waiting;
    assign rsp.table_full       = out_reg.table_full;

`ifndef SYNTH
    // More entries can never be finished than were loaded.
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        finished_count_reg <= entry_count_reg)
        else $error("finished count exceeds entry count");

    // The finished marks and the finished count tell the same story.
    a_marks_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(finished_marks_reg) == int'(finished_count_reg))
        else $error("finished marks disagree with finished count");

    // Table reads and write-backs are never issued in the same cycle.
    a_ram_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("table read and write overlap");

    // A scan only visits loaded entries.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pps_pkg::ST_SCAN) |-> (CNT_W'(rd_idx_reg) < entry_count_reg))
        else $error("scan index beyond loaded entries");
`endif

endmodule
